// ===== hw/rtl/otsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsa_pkg
// Shared types, defaults and codes of the object tree slot allocator.
// ----------------------------------------------------------------------------
package otsa_pkg;

    localparam int TableSizeDef   = 256;
    localparam int WindowSlotsDef = 4;

    localparam logic [14:0] ScreenWidthRst  = 15'd640;
    localparam logic [14:0] ScreenHeightRst = 15'd200;

    // Command codes.
    localparam logic [1:0] OP_INIT       = 2'd0;
    localparam logic [1:0] OP_WIN_ALLOC  = 2'd1;
    localparam logic [1:0] OP_WIN_FREE   = 2'd2;
    localparam logic [1:0] OP_ITEM_ALLOC = 2'd3;

    // Result codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Configuration register indexes.
    localparam logic [7:0] CFG_SCREEN_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_SCREEN_HEIGHT = 8'd1;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         target_index;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] slot_index;
    } t_out_word;

endpackage

// ===== hw/rtl/otsa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module otsa_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== hw/rtl/object_tree_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_tree_slot_allocator_unit
// Object table allocator: link and rectangle memories driven by a sequencer.
// ----------------------------------------------------------------------------
// Sequencing: init writes one table row a cycle; window alloc examines the
// window slots in turn; window free unlinks each child in turn; item alloc
// searches the item slots round-robin. A new input word is taken only in the
// idle state, once the previous command has finished; each memory has a
// single read port. After reset a clearing pass over every table row runs
// while no input word is accepted; configuration writes are taken at any time.
module object_tree_slot_allocator_unit
    import otsa_pkg::*;
#(
    parameter int TABLE_SIZE   = otsa_pkg::TableSizeDef,
    parameter int WINDOW_SLOTS = otsa_pkg::WindowSlotsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  otsa_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output otsa_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import otsa_pkg::*;

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int LW    = IW + 1;
    localparam int FIRST = WINDOW_SLOTS + 2;
    localparam int LIM   = (FIRST < TABLE_SIZE) ? FIRST : TABLE_SIZE;
    localparam int LAST  = LIM - 1;
    localparam int NITEM = (FIRST < TABLE_SIZE) ? TABLE_SIZE - FIRST : 1;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SWEEP   = 4'd1;
    localparam logic [3:0] S_WA_RD   = 4'd2;
    localparam logic [3:0] S_WA_CHK  = 4'd3;
    localparam logic [3:0] S_WF_HEAD = 4'd4;
    localparam logic [3:0] S_WF_CUR  = 4'd5;
    localparam logic [3:0] S_WF_LOOP = 4'd6;
    localparam logic [3:0] S_WF_CLR  = 4'd7;
    localparam logic [3:0] S_WF_END  = 4'd8;
    localparam logic [3:0] S_IA_RD   = 4'd9;
    localparam logic [3:0] S_IA_CHK  = 4'd10;
    localparam logic [3:0] S_IA_TAIL = 4'd11;
    localparam logic [3:0] S_IA_LINK = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;
    localparam logic [3:0] S_IA_FIX  = 4'd14;

    logic [3:0]    r_state, n_state;
    logic          r_sweep_init, n_sweep_init;
    logic [LW-1:0] r_addr, n_addr;
    t_in_word      r_in, n_in;
    logic [IW-1:0] r_ix, n_ix;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [1:0]    r_status, n_status;
    logic [7:0]    r_slot, n_slot;
    logic          r_out_valid;
    t_out_word     r_out_word;
    logic [14:0]   r_scr_w, r_scr_h;

    // Memory ports.
    logic          nx_we, hd_we, tl_we, rc_we;
    logic [IW-1:0] nx_waddr, hd_waddr, tl_waddr, rc_waddr;
    logic [LW-1:0] nx_wdata, hd_wdata, tl_wdata;
    logic [63:0]   rc_wdata;
    logic [IW-1:0] nx_raddr, hd_raddr, tl_raddr, rc_raddr;
    logic [LW-1:0] nx_rdata, hd_rdata, tl_rdata;
    logic [63:0]   rc_rdata;

    otsa_ram #(.Width(LW), .Depth(TABLE_SIZE)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(nx_raddr), .o_rdata(nx_rdata));
    otsa_ram #(.Width(LW), .Depth(TABLE_SIZE)) u_head_ram (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata));
    otsa_ram #(.Width(LW), .Depth(TABLE_SIZE)) u_tail_ram (
        .i_clk(i_clk), .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(tl_raddr), .o_rdata(tl_rdata));
    otsa_ram #(.Width(64), .Depth(TABLE_SIZE)) u_rect_ram (
        .i_clk(i_clk), .i_we(rc_we), .i_waddr(rc_waddr), .i_wdata(rc_wdata),
        .i_raddr(rc_raddr), .o_rdata(rc_rdata));

    logic [IW-1:0] w_tgt_ix;
    logic          w_tgt_out;
    logic [IW-1:0] w_ix_wrap;
    logic [IW-1:0] w_sweep_a;
    logic [63:0]   w_in_rect;
    logic          w_out_free;

    assign w_tgt_ix   = IW'(r_in.target_index);
    assign w_tgt_out  = (32'(r_in.target_index) >= TABLE_SIZE);
    assign w_ix_wrap  = (32'(r_ix) == TABLE_SIZE - 1) ? IW'(FIRST) : r_ix + 1'b1;
    assign w_sweep_a  = r_addr[IW-1:0];
    assign w_in_rect  = {r_in.rect_h, r_in.rect_w, r_in.rect_y, r_in.rect_x};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Command sequencer.
    always_comb begin
        n_state = r_state; n_sweep_init = r_sweep_init; n_addr = r_addr;
        n_in = r_in; n_ix = r_ix; n_cur = r_cur; n_cnt = r_cnt;
        n_cursor = r_cursor; n_status = r_status; n_slot = r_slot;
        nx_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0; rc_we = 1'b0;
        nx_waddr = r_ix; hd_waddr = r_ix; tl_waddr = r_ix; rc_waddr = r_ix;
        nx_wdata = NIL; hd_wdata = NIL; tl_wdata = NIL; rc_wdata = w_in_rect;
        nx_raddr = r_ix; hd_raddr = w_tgt_ix; tl_raddr = w_tgt_ix; rc_raddr = r_ix;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_word;
                    n_status = ST_OK;
                    n_slot = 8'd0;
                    unique case (i_in_word.opcode)
                        OP_INIT: begin
                            n_sweep_init = 1'b1;
                            n_addr = '0;
                            n_cursor = IW'(FIRST);
                            n_state = S_SWEEP;
                        end
                        OP_WIN_ALLOC: begin
                            n_ix = IW'(2);
                            n_state = S_WA_RD;
                        end
                        OP_WIN_FREE: begin
                            n_state = S_WF_HEAD;
                        end
                        default: begin
                            n_state = S_IA_FIX;
                        end
                    endcase
                end
            end
            // One table row per cycle: reset clearing or init pattern.
            S_SWEEP: begin
                nx_we = 1'b1; hd_we = 1'b1; tl_we = 1'b1;
                nx_waddr = w_sweep_a; hd_waddr = w_sweep_a;
                tl_waddr = w_sweep_a; rc_waddr = w_sweep_a;
                rc_wdata = 64'd0;
                if (!r_sweep_init) begin
                    rc_we = 1'b1;
                end else begin
                    if (32'(w_sweep_a) >= 1 && 32'(w_sweep_a) < LAST) begin
                        nx_wdata = LW'(32'(w_sweep_a) + 1);
                    end else if (32'(w_sweep_a) == LAST) begin
                        nx_wdata = '0;
                    end
                    if (w_sweep_a == '0) begin
                        hd_wdata = LW'(1);
                        tl_wdata = LW'(LAST);
                        rc_wdata = {1'b0, r_scr_h, 1'b0, r_scr_w, 32'd0};
                    end
                    rc_we = (32'(w_sweep_a) <= LAST);
                end
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == TABLE_SIZE - 1) begin
                    n_state = r_sweep_init ? S_DONE : S_IDLE;
                end
            end
            S_WA_RD: begin
                rc_raddr = r_ix;
                n_state = S_WA_CHK;
            end
            S_WA_CHK: begin
                if (rc_rdata[47:32] == 16'd0 || rc_rdata[63:48] == 16'd0) begin
                    rc_we = 1'b1;
                    n_slot = 8'(r_ix);
                    n_state = S_DONE;
                end else if (32'(r_ix) + 1 >= LIM) begin
                    n_status = ST_NO_SLOT;
                    n_state = S_DONE;
                end else begin
                    n_ix = r_ix + 1'b1;
                    n_state = S_WA_RD;
                end
            end
            S_WF_HEAD: begin
                if (w_tgt_out) begin
                    n_status = ST_REFUSED;
                    n_state = S_DONE;
                end else begin
                    rc_we = 1'b1;
                    rc_waddr = w_tgt_ix;
                    n_state = S_WF_CUR;
                end
            end
            S_WF_CUR: begin
                if (32'(hd_rdata) >= FIRST && 32'(hd_rdata) < TABLE_SIZE) begin
                    n_cursor = IW'(hd_rdata);
                end
                n_cur = hd_rdata;
                n_cnt = '0;
                n_state = S_WF_LOOP;
            end
            // Walk the child chain, unlinking each entry.
            S_WF_LOOP: begin
                nx_raddr = IW'(r_cur);
                if (32'(r_cur) < TABLE_SIZE && 32'(r_cur) > 32'(r_in.target_index)
                        && 32'(r_cnt) < TABLE_SIZE) begin
                    n_state = S_WF_CLR;
                end else begin
                    n_state = S_WF_END;
                end
            end
            S_WF_CLR: begin
                nx_we = 1'b1;
                nx_waddr = IW'(r_cur);
                n_cur = nx_rdata;
                n_cnt = r_cnt + 1'b1;
                n_state = S_WF_LOOP;
            end
            S_WF_END: begin
                hd_we = 1'b1; tl_we = 1'b1;
                hd_waddr = w_tgt_ix; tl_waddr = w_tgt_ix;
                n_state = S_DONE;
            end
            S_IA_FIX: begin
                if (FIRST >= TABLE_SIZE) begin
                    n_status = ST_NO_SLOT;
                    n_state = S_DONE;
                end else begin
                    if (32'(r_cursor) < FIRST || 32'(r_cursor) >= TABLE_SIZE) begin
                        n_cursor = IW'(FIRST);
                        n_ix = IW'(FIRST);
                    end else begin
                        n_ix = r_cursor;
                    end
                    n_cnt = '0;
                    n_state = S_IA_RD;
                end
            end
            S_IA_RD: begin
                nx_raddr = r_ix;
                n_state = S_IA_CHK;
            end
            // Free slot found when its next link is NIL.
            S_IA_CHK: begin
                if (nx_rdata == NIL) begin
                    hd_we = 1'b1; tl_we = 1'b1;
                    if (w_tgt_out || w_tgt_ix == r_ix) begin
                        n_status = ST_REFUSED;
                        n_state = S_DONE;
                    end else begin
                        tl_raddr = w_tgt_ix;
                        n_state = S_IA_TAIL;
                    end
                end else if (32'(r_cnt) + 1 >= NITEM) begin
                    n_status = ST_NO_SLOT;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_ix = w_ix_wrap;
                    n_state = S_IA_RD;
                end
            end
            S_IA_TAIL: begin
                if (tl_rdata != NIL && 32'(tl_rdata) >= TABLE_SIZE) begin
                    n_status = ST_REFUSED;
                    n_state = S_DONE;
                end else begin
                    if (tl_rdata == NIL) begin
                        hd_we = 1'b1;
                        hd_waddr = w_tgt_ix;
                        hd_wdata = LW'(r_ix);
                    end else begin
                        nx_we = 1'b1;
                        nx_waddr = IW'(tl_rdata);
                        nx_wdata = LW'(r_ix);
                    end
                    tl_we = 1'b1;
                    tl_waddr = w_tgt_ix;
                    tl_wdata = LW'(r_ix);
                    rc_we = 1'b1;
                    n_state = S_IA_LINK;
                end
            end
            S_IA_LINK: begin
                nx_we = 1'b1;
                nx_wdata = LW'(w_tgt_ix);
                n_cursor = w_ix_wrap;
                n_slot = 8'(r_ix);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep_init <= 1'b0;
            r_addr <= '0;
            r_cursor <= IW'(FIRST);
            r_out_valid <= 1'b0;
            r_scr_w <= ScreenWidthRst;
            r_scr_h <= ScreenHeightRst;
        end else begin
            r_state <= n_state;
            r_sweep_init <= n_sweep_init;
            r_addr <= n_addr;
            r_cursor <= n_cursor;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && i_cfg_index == CFG_SCREEN_WIDTH) begin
                r_scr_w <= i_cfg_data[14:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_SCREEN_HEIGHT) begin
                r_scr_h <= i_cfg_data[14:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_ix <= n_ix;
        r_cur <= n_cur;
        r_cnt <= n_cnt;
        r_status <= n_status;
        r_slot <= n_slot;
        if (r_state == S_DONE && w_out_free) begin
            r_out_word.status <= r_status;
            r_out_word.slot_index <= r_slot;
        end
    end
endmodule

// ===== hw/rtl/otsa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsa_checker
// Port-level assertions for the object tree slot allocator, bound to the top.
// ----------------------------------------------------------------------------
module otsa_checker
    import otsa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input otsa_pkg::t_out_word o_out_word
);
    import otsa_pkg::*;

    // A waiting result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // The block never accepts command words in back-to-back cycles.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted on back-to-back cycles");

    // A failed command never reports a slot.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.slot_index == 8'd0)
        else $error("slot reported with a failure status");

    // Status stays within its defined codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.status == ST_OK || o_out_word.status == ST_NO_SLOT
            || o_out_word.status == ST_REFUSED)
        else $error("undefined status code");
endmodule

bind object_tree_slot_allocator_unit otsa_checker u_otsa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_word(o_out_word));

// ===== tb/otsa_tree_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsa_tree_checker
// Watches the command, result and register channels of the object tree slot
// allocator, keeps its own copy of the object table, and compares every
// result word with the value that the table copy predicts.
// ----------------------------------------------------------------------------
module otsa_tree_checker
    import otsa_pkg::*;
#(
    parameter int TABLE_SIZE   = otsa_pkg::TableSizeDef,
    parameter int WINDOW_SLOTS = otsa_pkg::WindowSlotsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    localparam int NIL        = -1;
    localparam int FIRST_ITEM = WINDOW_SLOTS + 2;

    // Table copy: links as plain indexes, rectangles packed as {x, y, w, h}.
    int          next_link [TABLE_SIZE];
    int          head_link [TABLE_SIZE];
    int          tail_link [TABLE_SIZE];
    logic [63:0] rect_mem  [TABLE_SIZE];
    int          cursor;
    logic [14:0] scr_w;
    logic [14:0] scr_h;

    t_out_word result_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Clear every link of the table.
    function automatic void clear_links();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            next_link[i] = NIL;
            head_link[i] = NIL;
            tail_link[i] = NIL;
        end
    endfunction

    // Append a child at the end of the parent's child list.
    function automatic bit link_child(int parent, int child);
        int last;
        if (parent >= TABLE_SIZE || child >= TABLE_SIZE || child == parent) return 0;
        if (next_link[child] != NIL) return 0;
        last = tail_link[parent];
        if (last == NIL) begin
            head_link[parent] = child;
        end else begin
            if (last >= TABLE_SIZE) return 0;
            next_link[last] = child;
        end
        next_link[child]  = parent;
        tail_link[parent] = child;
        return 1;
    endfunction

    // Apply one command word to the table copy and return its result word.
    function automatic t_out_word run_command(t_in_word w);
        t_out_word   r;
        int          tgt;
        int          cur;
        int          nx;
        int          steps;
        int          ix;
        bit          found;
        logic [63:0] new_rect;
        r.status     = ST_OK;
        r.slot_index = '0;
        tgt          = int'(w.target_index);
        new_rect     = {w.rect_x, w.rect_y, w.rect_w, w.rect_h};
        case (w.opcode)
            OP_INIT: begin
                clear_links();
                cursor      = FIRST_ITEM;
                rect_mem[0] = {32'd0, 1'b0, scr_w, 1'b0, scr_h};
                for (int i = 1; i < FIRST_ITEM && i < TABLE_SIZE; i++) begin
                    rect_mem[i] = '0;
                    void'(link_child(0, i));
                end
            end
            OP_WIN_ALLOC: begin
                r.status = ST_NO_SLOT;
                for (int i = 2; i < FIRST_ITEM && i < TABLE_SIZE; i++) begin
                    if (rect_mem[i][31:16] == 16'd0 || rect_mem[i][15:0] == 16'd0) begin
                        rect_mem[i]  = new_rect;
                        r.status     = ST_OK;
                        r.slot_index = i[7:0];
                        break;
                    end
                end
            end
            OP_WIN_FREE: begin
                if (tgt >= TABLE_SIZE) begin
                    r.status = ST_REFUSED;
                end else begin
                    cur           = head_link[tgt];
                    steps         = 0;
                    rect_mem[tgt] = new_rect;
                    if (cur >= FIRST_ITEM && cur < TABLE_SIZE) cursor = cur;
                    // Walk the child chain and detach each child.
                    while (cur != NIL && cur > tgt && cur < TABLE_SIZE
                           && steps < TABLE_SIZE) begin
                        nx             = next_link[cur];
                        next_link[cur] = NIL;
                        cur            = nx;
                        steps++;
                    end
                    head_link[tgt] = NIL;
                    tail_link[tgt] = NIL;
                end
            end
            default: begin
                r.status = ST_NO_SLOT;
                if (FIRST_ITEM < TABLE_SIZE) begin
                    found = 0;
                    if (cursor < FIRST_ITEM || cursor >= TABLE_SIZE) cursor = FIRST_ITEM;
                    ix = cursor;
                    // Round-robin search for an unlinked item slot.
                    for (int i = 0; i < TABLE_SIZE - FIRST_ITEM; i++) begin
                        if (next_link[ix] == NIL) begin
                            found = 1;
                            break;
                        end
                        ix++;
                        if (ix >= TABLE_SIZE) ix = FIRST_ITEM;
                    end
                    if (found) begin
                        head_link[ix] = NIL;
                        tail_link[ix] = NIL;
                        if (!link_child(tgt, ix)) begin
                            r.status = ST_REFUSED;
                        end else begin
                            rect_mem[ix] = new_rect;
                            cursor       = (ix + 1 >= TABLE_SIZE) ? FIRST_ITEM : ix + 1;
                            r.status     = ST_OK;
                            r.slot_index = ix[7:0];
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Track the channels: predict on each command word, compare on each result.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            clear_links();
            for (int i = 0; i < TABLE_SIZE; i++) rect_mem[i] = '0;
            cursor = FIRST_ITEM;
            scr_w  = ScreenWidthRst;
            scr_h  = ScreenHeightRst;
            result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  scr_w = i_cfg_data[14:0];
                    CFG_SCREEN_HEIGHT: scr_h = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) result_q.push_back(run_command(i_in_word));
            if (i_out_valid && i_out_ready) begin
                if (result_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result word with none expected, actual status %0d slot %0d",
                             $time, i_out_word.status, i_out_word.slot_index);
                end else begin
                    exp_w = result_q.pop_front();
                    o_checked++;
                    if (i_out_word.status !== exp_w.status) begin
                        o_fail_count++;
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, exp_w.status, i_out_word.status);
                    end
                    if (i_out_word.slot_index !== exp_w.slot_index) begin
                        o_fail_count++;
                        $display("%0t: slot_index mismatch, expected %0d actual %0d",
                                 $time, exp_w.slot_index, i_out_word.slot_index);
                    end
                end
            end
        end
        o_pending <= result_q.size();
    end

endmodule

// ===== tb/object_tree_slot_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_tree_slot_allocator_unit_tb
// Drives directed and random command words into the allocator under random
// idle gaps and result back-pressure, changes the screen size between phases,
// and takes the verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module object_tree_slot_allocator_unit_tb;
    import otsa_pkg::*;

    localparam int TABLE_SIZE    = TableSizeDef;
    localparam int WINDOW_SLOTS  = WindowSlotsDef;
    localparam int FIRST_ITEM    = WINDOW_SLOTS + 2;
    localparam int SETTLE_CYCLES = 2 * TABLE_SIZE + 32;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_word    in_word   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    t_out_word   out_word;
    logic        cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int stall_left = 0;
    int op_count[4];
    bit sender_idle_off = 0;
    bit recv_idle_off   = 0;

    t_in_word cmd_q[$];

    object_tree_slot_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    otsa_tree_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Result side: after each word, hold ready low for a random stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                stall_left = recv_idle_off ? 0 : $urandom_range(0, 15);
            end else if (!out_ready && stall_left > 0) begin
                stall_left--;
            end
            out_ready <= (stall_left == 0);
        end
    end

    // Hard limit on the run time.
    initial begin
        #40_000_000;
        $display("%0t: run timed out", $time);
        $display("[object_tree_slot_allocator_unit] ERROR");
        $finish;
    end

    function automatic void push_cmd(logic [1:0] op, int tgt, logic [15:0] x,
                                     logic [15:0] y, logic [15:0] w, logic [15:0] h);
        t_in_word c;
        c.opcode       = op;
        c.target_index = tgt[7:0];
        c.rect_x       = x;
        c.rect_y       = y;
        c.rect_w       = w;
        c.rect_h       = h;
        op_count[op]++;
        cmd_q.push_back(c);
    endfunction

    // One rectangle coordinate, with the extremes and zero drawn often.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // A random command, biased toward windows and the root as targets.
    function automatic void push_random_cmd();
        int         pick;
        int         tgt;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        tgt  = $urandom_range(0, 255);
        if (pick < 4) begin
            op = OP_INIT;
        end else if (pick < 16) begin
            op = OP_WIN_ALLOC;
        end else if (pick < 36) begin
            op   = OP_WIN_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 70) tgt = $urandom_range(2, FIRST_ITEM - 1);
            else if (pick < 80) tgt = $urandom_range(0, 1);
        end else begin
            op   = OP_ITEM_ALLOC;
            pick = $urandom_range(0, 99);
            if (pick < 60) tgt = $urandom_range(0, FIRST_ITEM - 1);
            else if (pick < 90) tgt = $urandom_range(FIRST_ITEM, 255);
        end
        push_cmd(op, tgt, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endfunction

    task automatic write_cfg(logic [7:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send every queued command word, with a random gap before each one.
    task automatic drive_cmds();
        int gap;
        bit pend;
        pend = 0;
        gap  = sender_idle_off ? 0 : $urandom_range(0, 15);
        while (pend || cmd_q.size() > 0) begin
            if (!pend) begin
                repeat (gap) @(posedge i_clk);
                in_valid <= 1'b1;
                in_word  <= cmd_q.pop_front();
                pend = 1;
            end
            @(posedge i_clk);
            if (in_ready) begin
                gap = sender_idle_off ? 0 : $urandom_range(0, 15);
                if (gap == 0 && cmd_q.size() > 0) begin
                    in_word <= cmd_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                    pend = 0;
                end
            end
        end
    endtask

    // Hold off until every expected result has come back.
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(CFG_SCREEN_WIDTH, 16'hFFFF);
        write_cfg(CFG_SCREEN_HEIGHT, 16'h0000);

        // Directed commands: an alloc before any init, parent equal to the
        // slot, window exhaustion, a parent outside the windows, and frees of
        // a window with children, of the root and of the last entry.
        push_cmd(OP_ITEM_ALLOC, 0, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001);
        push_cmd(OP_INIT, 0, 16'h0, 16'h0, 16'h0, 16'h0);
        push_cmd(OP_ITEM_ALLOC, FIRST_ITEM, 16'h1, 16'h2, 16'h3, 16'h4);
        push_cmd(OP_WIN_ALLOC, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        push_cmd(OP_WIN_ALLOC, 0, 16'h0010, 16'h0020, 16'h0000, 16'h0005);
        push_cmd(OP_WIN_ALLOC, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_cmd(OP_WIN_ALLOC, 0, 16'h0001, 16'h0001, 16'h0001, 16'h0001);
        push_cmd(OP_WIN_ALLOC, 0, 16'h0002, 16'h0002, 16'h0002, 16'h0002);
        push_cmd(OP_WIN_ALLOC, 0, 16'h0003, 16'h0003, 16'h0003, 16'h0003);
        push_cmd(OP_ITEM_ALLOC, 2, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        push_cmd(OP_ITEM_ALLOC, 2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_cmd(OP_ITEM_ALLOC, 255, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_cmd(OP_ITEM_ALLOC, 3, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        push_cmd(OP_WIN_FREE, 2, 16'h0000, 16'h0000, 16'h0000, 16'h0009);
        push_cmd(OP_ITEM_ALLOC, 2, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
        push_cmd(OP_WIN_FREE, 0, 16'h0005, 16'h0006, 16'h0007, 16'h0008);
        push_cmd(OP_WIN_FREE, 255, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        push_cmd(OP_ITEM_ALLOC, 1, 16'h00AA, 16'h00BB, 16'h00CC, 16'h00DD);
        push_cmd(OP_WIN_ALLOC, 0, 16'h0004, 16'h0004, 16'h0004, 16'h0004);
        push_cmd(OP_INIT, 0, 16'h0, 16'h0, 16'h0, 16'h0);
        drive_cmds();
        wait_idle();

        // Random phases with a new screen size each; phase 3 fills the table.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_cfg(CFG_SCREEN_WIDTH, 16'h0000);
                    write_cfg(CFG_SCREEN_HEIGHT, 16'h7FFF);
                end
                4: begin
                    write_cfg(CFG_SCREEN_WIDTH, 16'd640);
                    write_cfg(CFG_SCREEN_HEIGHT, 16'd200);
                end
                default: begin
                    write_cfg(CFG_SCREEN_WIDTH, 16'($urandom_range(0, 16'hFFFF)));
                    write_cfg(CFG_SCREEN_HEIGHT, 16'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            sender_idle_off = (phase == 5);
            recv_idle_off   = (phase == 5 || phase == 2);
            push_cmd(OP_INIT, $urandom_range(0, 255), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord());
            if (phase == 3) begin
                for (int k = 0; k < TABLE_SIZE - FIRST_ITEM + 6; k++) begin
                    push_cmd(OP_ITEM_ALLOC, $urandom_range(0, FIRST_ITEM - 1),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord());
                end
                for (int k = 0; k < 20; k++) push_random_cmd();
            end else begin
                for (int k = 0; k < 130; k++) push_random_cmd();
            end
            drive_cmds();
            wait_idle();
        end

        if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
        $display("Commands sent: %0d init, %0d window alloc, %0d window free, %0d item alloc.",
                 op_count[OP_INIT], op_count[OP_WIN_ALLOC], op_count[OP_WIN_FREE],
                 op_count[OP_ITEM_ALLOC]);
        $display("Result words checked: %0d, under nine screen size settings.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("[object_tree_slot_allocator_unit] OK");
        end else begin
            $display("[object_tree_slot_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
